[sv/haft_pkg.sv]
// Shared types and constants for the hashed address frequency table.
package haft_pkg;

  // Multiplicative hash constant and field widths.
  localparam logic [63:0] GOLDEN       = 64'h9E3779B97F4A7C15;
  localparam int          ADDR_W       = 64;
  localparam int          COUNT_W      = 32;
  localparam int          LEN_W        = 17;
  localparam int          MAXOUT_W     = 7;
  localparam int          HASH_W       = 24;
  localparam int          HASH_LSB     = 40;
  localparam int          CFG_IDX_W    = 2;
  localparam int          CFG_DATA_W   = 17;
  localparam logic [LEN_W-1:0]   BLOCK_BYTES   = 17'd65536;
  localparam logic [LEN_W-1:0]   COPY_RESET    = 17'd4096;
  localparam logic [LEN_W-1:0]   MIN_RESET     = 17'd2304;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 32'hFFFF_FFFF;

  // Defaults for the top-level parameters.
  localparam int DEF_TABLE_SLOTS = 128;
  localparam int DEF_PROBE_LIMIT = 4;
  localparam int DEF_MAX_EMIT    = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACKING = 2'd0,
    CFG_COPY     = 2'd1,
    CFG_MIN      = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

[sv/haft_if.sv]
// Channel interfaces for note/drain transactions and result transactions.
interface haft_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [haft_pkg::ADDR_W-1:0]      address;
  logic [haft_pkg::MAXOUT_W-1:0]    max_out;

  modport source (output valid, kind, address, max_out, input ready);
  modport sink   (input valid, kind, address, max_out, output ready);
endinterface

interface haft_out_if;
  logic                             valid;
  logic                             ready;
  logic [haft_pkg::ADDR_W-1:0]      cand_address;
  logic [haft_pkg::COUNT_W-1:0]     bind_count;
  logic [haft_pkg::LEN_W-1:0]       copy_len;
  logic                             found;
  logic                             last;

  modport source (output valid, cand_address, bind_count, copy_len, found, last,
                  input ready);
  modport sink   (input valid, cand_address, bind_count, copy_len, found, last,
                  output ready);
endinterface

[sv/hashed_address_frequency_table_top.sv]
// Hashed address frequency table: counting notes and sorted draining.
// Note: the hash is built on one shared 32x32 multiplier; a power-of-two table takes
//   the low hash bits as the slot index, else a restoring subtract loop reduces the hash;
//   each probe then reads a slot through the registered table read port and checks it.
// Drain: one full scan of the table per emitted entry, plus a final scan when fewer
//   entries than the limit are found; the table clears as the last result is emitted.
// Reset (rst, synchronous) clears all slot valid/taken bits and resets state and config.
module hashed_address_frequency_table_top #(
  parameter int TABLE_SLOTS = haft_pkg::DEF_TABLE_SLOTS,
  parameter int PROBE_LIMIT = haft_pkg::DEF_PROBE_LIMIT,
  parameter int MAX_EMIT    = haft_pkg::DEF_MAX_EMIT
) (
  input  logic                              clk,
  input  logic                              rst,
  haft_in_if.sink                           in_ch,
  haft_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [haft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [haft_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int  IDX_W  = $clog2(TABLE_SLOTS);
  localparam int  CNT_W  = IDX_W + 1;
  localparam int  PRB_W  = $clog2(PROBE_LIMIT + 1);
  localparam bit  POW2   = (TABLE_SLOTS == (1 << IDX_W));
  localparam int  KTOP   = haft_pkg::HASH_W - IDX_W;
  localparam int  DV_W   = haft_pkg::HASH_W + 1;
  localparam logic [DV_W-1:0] DV_INIT = DV_W'(TABLE_SLOTS) << KTOP;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [PRB_W-1:0] PRB_LAST = PRB_W'(PROBE_LIMIT - 1);
  localparam logic [haft_pkg::MAXOUT_W-1:0] EMIT_C = haft_pkg::MAXOUT_W'(MAX_EMIT);

  // Configuration registers.
  logic                         tracking;
  logic [haft_pkg::LEN_W-1:0]   copy_bytes;
  logic [haft_pkg::LEN_W-1:0]   min_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking   <= 1'b0;
      copy_bytes <= haft_pkg::COPY_RESET;
      min_bytes  <= haft_pkg::MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        haft_pkg::CFG_TRACKING: tracking   <= cfg_data[0];
        haft_pkg::CFG_COPY:     copy_bytes <= cfg_data;
        haft_pkg::CFG_MIN:      min_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot memories, with valid and taken bits held in flops.
  logic [haft_pkg::ADDR_W-1:0]  addr_mem [TABLE_SLOTS];
  logic [haft_pkg::COUNT_W-1:0] cnt_mem  [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]       vld;
  logic [TABLE_SLOTS-1:0]       tkn;

  haft_pkg::state_t state, state_next;

  // Datapath registers.
  logic [haft_pkg::ADDR_W-1:0]  note_addr;
  logic [1:0]                   mul_step;
  logic [63:0]                  prod;
  logic [63:0]                  acc;
  logic [haft_pkg::HASH_W-1:0]  rem;
  logic [DV_W-1:0]              dv;
  logic [4:0]                   kcnt;
  logic [IDX_W-1:0]             probe_idx;
  logic [PRB_W-1:0]             probe_n;
  logic [CNT_W-1:0]             scan_cnt;
  logic                         rd_ok;
  logic [IDX_W-1:0]             rd_idx;
  logic [haft_pkg::ADDR_W-1:0]  rd_addr;
  logic [haft_pkg::COUNT_W-1:0] rd_cnt;
  logic                         rd_vld;
  logic                         rd_tkn;
  logic [IDX_W-1:0]             best_idx;
  logic [haft_pkg::ADDR_W-1:0]  best_addr;
  logic [haft_pkg::COUNT_W-1:0] best_cnt;
  logic [haft_pkg::LEN_W-1:0]   best_len;
  logic                         pend_ok;
  logic [haft_pkg::ADDR_W-1:0]  pend_addr;
  logic [haft_pkg::COUNT_W-1:0] pend_cnt;
  logic [haft_pkg::LEN_W-1:0]   pend_len;
  logic [haft_pkg::MAXOUT_W-1:0] limit;
  logic [haft_pkg::MAXOUT_W-1:0] sel;
  logic                         emit_last;
  logic                         out_valid;

  // Combinational helpers.
  logic                         in_acc;
  logic                         out_free;
  logic                         scan_issue;
  logic [IDX_W-1:0]             rd_sel;
  logic [31:0]                  mul_a;
  logic [31:0]                  mul_b;
  logic [63:0]                  acc_sum;
  logic [haft_pkg::HASH_W-1:0]  rem_step;
  logic [haft_pkg::LEN_W-1:0]   avail;
  logic [haft_pkg::LEN_W-1:0]   rd_len;
  logic                         better;
  logic                         found;
  logic                         hit;
  logic [haft_pkg::COUNT_W-1:0] cnt_inc;
  logic [haft_pkg::MAXOUT_W-1:0] lim_in;

  assign in_ch.ready = (state == haft_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign scan_issue  = (scan_cnt < SLOTS_C);
  assign lim_in      = (in_ch.max_out > EMIT_C) ? EMIT_C : in_ch.max_out;

  // Shared multiplier operands: low product of (address >> 8) and the hash constant.
  always_comb begin
    unique case (mul_step)
      2'd0: begin
        mul_a = note_addr[39:8];
        mul_b = haft_pkg::GOLDEN[31:0];
      end
      2'd1: begin
        mul_a = note_addr[39:8];
        mul_b = haft_pkg::GOLDEN[63:32];
      end
      default: begin
        mul_a = {8'd0, note_addr[63:40]};
        mul_b = haft_pkg::GOLDEN[31:0];
      end
    endcase
  end
  assign acc_sum  = acc + {prod[31:0], 32'd0};
  assign rem_step = ({1'b0, rem} >= dv) ? rem - dv[haft_pkg::HASH_W-1:0] : rem;

  // Clipped copy length of the entry just read.
  assign avail  = haft_pkg::BLOCK_BYTES - {1'b0, rd_addr[15:0]};
  assign rd_len = ((copy_bytes < avail) ? copy_bytes : avail) & ~17'h0000F;
  assign better = rd_ok && rd_vld && !rd_tkn && (rd_len >= min_bytes) && (rd_cnt > best_cnt);
  assign found  = (best_cnt != '0);
  assign hit    = rd_vld && (rd_addr == note_addr);
  assign cnt_inc = (rd_cnt == haft_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
  assign rd_sel = (state == haft_pkg::ST_SCAN) ? scan_cnt[IDX_W-1:0] : probe_idx;

  // Registered table read port.
  always_ff @(posedge clk) begin
    rd_addr <= addr_mem[rd_sel];
    rd_cnt  <= cnt_mem[rd_sel];
    rd_vld  <= vld[rd_sel];
    rd_tkn  <= tkn[rd_sel];
    rd_idx  <= rd_sel;
  end

  // Table write port, used by the probe check.
  always_ff @(posedge clk) begin
    if (state == haft_pkg::ST_PRB_CHK) begin
      if (hit) begin
        cnt_mem[probe_idx] <= cnt_inc;
      end else if (!rd_vld) begin
        addr_mem[probe_idx] <= note_addr;
        cnt_mem[probe_idx]  <= 32'd1;
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= haft_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      haft_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind) begin
            state_next = (lim_in == '0) ? haft_pkg::ST_EMIT : haft_pkg::ST_SCAN;
          end else if (in_ch.address != '0 && tracking) begin
            state_next = haft_pkg::ST_HASH;
          end
        end
      end
      haft_pkg::ST_HASH: begin
        if (mul_step == 2'd3) state_next = haft_pkg::ST_MOD;
      end
      haft_pkg::ST_MOD: begin
        if (POW2 || kcnt == '0) state_next = haft_pkg::ST_PRB_RD;
      end
      haft_pkg::ST_PRB_RD: state_next = haft_pkg::ST_PRB_CHK;
      haft_pkg::ST_PRB_CHK: begin
        if (hit || !rd_vld || probe_n == PRB_LAST) state_next = haft_pkg::ST_IDLE;
        else state_next = haft_pkg::ST_PRB_RD;
      end
      haft_pkg::ST_SCAN: begin
        if (!scan_issue && !rd_ok) state_next = haft_pkg::ST_PICK;
      end
      haft_pkg::ST_PICK: begin
        if (!found || pend_ok || sel + 7'd1 == limit) state_next = haft_pkg::ST_EMIT;
        else state_next = haft_pkg::ST_SCAN;
      end
      haft_pkg::ST_EMIT: begin
        if (out_free) begin
          if (emit_last) state_next = haft_pkg::ST_IDLE;
          else if (sel == limit) state_next = haft_pkg::ST_EMIT;
          else state_next = haft_pkg::ST_SCAN;
        end
      end
      default: state_next = haft_pkg::ST_IDLE;
    endcase
  end

  // Control flags: valid and taken bits, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      tkn       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid <= 1'b0;
      if (state == haft_pkg::ST_PRB_CHK && !hit && !rd_vld) vld[probe_idx] <= 1'b1;
      if (state == haft_pkg::ST_PICK && found) tkn[best_idx] <= 1'b1;
      if (state == haft_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
        if (emit_last) begin
          vld <= '0;
          tkn <= '0;
        end
      end
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      haft_pkg::ST_IDLE: begin
        note_addr <= in_ch.address;
        mul_step  <= 2'd0;
        limit     <= lim_in;
        sel       <= '0;
        pend_ok   <= 1'b0;
        emit_last <= 1'b1;
        scan_cnt  <= '0;
        rd_ok     <= 1'b0;
        best_cnt  <= '0;
      end
      haft_pkg::ST_HASH: begin
        prod     <= mul_a * mul_b;
        mul_step <= mul_step + 2'd1;
        if (mul_step == 2'd1) acc <= prod;
        else if (mul_step == 2'd2) acc <= acc_sum;
        if (mul_step == 2'd3) begin
          rem  <= acc_sum[haft_pkg::HASH_LSB +: haft_pkg::HASH_W];
          dv   <= DV_INIT;
          kcnt <= 5'(KTOP);
        end
      end
      haft_pkg::ST_MOD: begin
        probe_n <= '0;
        if (POW2) begin
          probe_idx <= rem[IDX_W-1:0];
        end else begin
          rem  <= rem_step;
          dv   <= dv >> 1;
          kcnt <= kcnt - 5'd1;
          probe_idx <= rem_step[IDX_W-1:0];
        end
      end
      haft_pkg::ST_PRB_RD: ;
      haft_pkg::ST_PRB_CHK: begin
        probe_n   <= probe_n + 1'b1;
        probe_idx <= (probe_idx == LAST_IDX) ? '0 : probe_idx + 1'b1;
      end
      haft_pkg::ST_SCAN: begin
        rd_ok <= scan_issue;
        if (scan_issue) scan_cnt <= scan_cnt + 1'b1;
        if (better) begin
          best_cnt  <= rd_cnt;
          best_addr <= rd_addr;
          best_idx  <= rd_idx;
          best_len  <= rd_len;
        end
      end
      haft_pkg::ST_PICK: begin
        scan_cnt <= '0;
        rd_ok    <= 1'b0;
        if (!found) begin
          emit_last <= 1'b1;
        end else begin
          sel <= sel + 7'd1;
          if (pend_ok) begin
            emit_last <= 1'b0;
          end else begin
            best_cnt  <= '0;
            pend_ok   <= 1'b1;
            pend_addr <= best_addr;
            pend_cnt  <= best_cnt;
            pend_len  <= best_len;
            emit_last <= (sel + 7'd1 == limit);
          end
        end
      end
      haft_pkg::ST_EMIT: begin
        if (out_free) begin
          out_ch.cand_address <= pend_ok ? pend_addr : '0;
          out_ch.bind_count   <= pend_ok ? pend_cnt : '0;
          out_ch.copy_len     <= pend_ok ? pend_len : '0;
          out_ch.found        <= pend_ok;
          out_ch.last         <= emit_last;
          if (!emit_last) begin
            pend_addr <= best_addr;
            pend_cnt  <= best_cnt;
            pend_len  <= best_len;
            best_cnt  <= '0;
            emit_last <= (sel == limit);
          end
        end
      end
      default: ;
    endcase
  end

endmodule
